// ----- rtl/wgcm_pkg.sv -----
// Package for the window gap cluster mean filter.
// Sizes, widths, shared types and the controller/datapath command and status structs.
// No dependencies.
package wgcm_pkg;

    localparam int WINDOW    = 7;
    localparam int FRAC_BITS = 8;
    localparam int SAMPLE_W  = 16;
    localparam int MEAN_W    = 24;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW + 1);
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int QX_W   = (NUM_W > MEAN_W) ? NUM_W : MEAN_W;
    localparam int STEP_W = $clog2(NUM_W + 2);
    localparam int HALF   = (WINDOW + 1) / 2;

    localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic             load;
        logic             sort_step;
        logic             sort_odd;
        logic             rot_step;
        logic             gap_eval;
        logic             sum_step;
        logic             div_init;
        logic             div_step;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/wgcm_dp.sv -----
// Datapath of the window gap cluster mean filter: sample window, sorted copy,
// gap search, cluster sum, restoring divider and output register.
// Depends on wgcm_pkg.
module wgcm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wgcm_pkg::t_cmd                i_cmd,
    output wgcm_pkg::t_sts                o_sts,
    input  wgcm_pkg::t_sample             i_sample,
    output logic [wgcm_pkg::MEAN_W-1:0]   o_mean,
    output logic                          o_lower,
    output logic                          o_valid,
    input  logic                          i_ready
);
    import wgcm_pkg::*;

    t_sample            r_win [WINDOW];
    t_sample            r_srt [WINDOW];
    t_sample            n_win [WINDOW];
    t_sample            n_srt [WINDOW];
    t_sample            r_best;
    logic [IDX_W-1:0]   r_split;
    logic [SUM_W-1:0]   r_sum;
    logic [NUM_W-1:0]   r_num;
    logic [IDX_W:0]     r_rem;
    logic [MEAN_W-1:0]  r_mean;
    logic               r_lower;
    logic               r_valid;

    t_sample            gap;
    logic [IDX_W:0]     split_p1;
    logic               lower;
    logic [IDX_W:0]     count;
    logic               in_range;
    logic [IDX_W+1:0]   trial;
    logic               ge;
    logic [QX_W-1:0]    q_ext;

    assign gap      = r_srt[1] - r_srt[0];
    assign split_p1 = {1'b0, r_split} + 1'b1;
    assign lower    = split_p1 > (IDX_W+1)'(HALF);
    assign count    = lower ? split_p1 : ((IDX_W+1)'(WINDOW - 1) - {1'b0, r_split});
    assign in_range = lower ? (i_cmd.idx <= r_split) : (i_cmd.idx > r_split);
    assign trial    = {r_rem, r_num[NUM_W-1]};
    assign ge       = trial >= {1'b0, count};
    assign q_ext    = QX_W'(r_num);

    always_comb begin
        for (int i = 0; i < WINDOW - 1; i++) begin
            n_win[i] = r_win[i+1];
        end
        n_win[WINDOW-1] = i_sample;

        for (int i = 0; i < WINDOW; i++) begin
            n_srt[i] = r_srt[i];
        end
        if (i_cmd.load) begin
            for (int i = 0; i < WINDOW; i++) begin
                n_srt[i] = n_win[i];
            end
        end else if (i_cmd.sort_step) begin
            for (int j = 0; j < WINDOW - 1; j++) begin
                if ((((j % 2) == 1) == i_cmd.sort_odd) && (r_srt[j] > r_srt[j+1])) begin
                    n_srt[j]   = r_srt[j+1];
                    n_srt[j+1] = r_srt[j];
                end
            end
        end else if (i_cmd.rot_step) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                n_srt[i] = r_srt[i+1];
            end
            n_srt[WINDOW-1] = r_srt[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_win[i] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_win <= n_win;
            end
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_srt <= n_srt;
        if (i_cmd.load) begin
            r_sum <= '0;
        end
        if (i_cmd.gap_eval && ((i_cmd.idx == '0) || (gap > r_best))) begin
            r_best  <= gap;
            r_split <= i_cmd.idx;
        end
        if (i_cmd.sum_step && in_range) begin
            r_sum <= r_sum + SUM_W'(r_srt[0]);
        end
        if (i_cmd.div_init) begin
            r_num <= NUM_W'(r_sum) << FRAC_BITS;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? (IDX_W+1)'(trial - {1'b0, count}) : (IDX_W+1)'(trial);
        end
        if (i_cmd.out_load) begin
            r_mean  <= (q_ext > QX_W'(MEAN_MAX)) ? MEAN_MAX : q_ext[MEAN_W-1:0];
            r_lower <= lower;
        end
    end

    assign o_sts.out_free = !r_valid || i_ready;
    assign o_mean         = r_mean;
    assign o_lower        = r_lower;
    assign o_valid        = r_valid;

endmodule

// ----- rtl/wgcm_ctrl.sv -----
// Controller of the window gap cluster mean filter: sequences load, sort,
// gap search, sum, divide and output steps. Depends on wgcm_pkg.
module wgcm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output wgcm_pkg::t_cmd o_cmd,
    input  wgcm_pkg::t_sts i_sts
);
    import wgcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_GAP,
        S_SUM,
        S_DIV,
        S_HOLD
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_cnt;
    logic                last_w;

    assign last_w     = r_cnt == STEP_W'(WINDOW - 1);
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd           = '0;
        o_cmd.idx       = r_cnt[IDX_W-1:0];
        o_cmd.sort_odd  = r_cnt[0];
        case (r_state)
            S_IDLE: o_cmd.load      = i_in_valid;
            S_SORT: o_cmd.sort_step = 1'b1;
            S_GAP: begin
                o_cmd.rot_step = 1'b1;
                o_cmd.gap_eval = !last_w;
            end
            S_SUM: begin
                o_cmd.rot_step = 1'b1;
                o_cmd.sum_step = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_init = r_cnt == '0;
                o_cmd.div_step = r_cnt != '0;
            end
            S_HOLD: o_cmd.out_load  = i_sts.out_free;
            default: o_cmd          = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        r_state <= S_SORT;
                    end
                end
                S_SORT: begin
                    if (last_w) begin
                        r_state <= S_GAP;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_GAP: begin
                    if (last_w) begin
                        r_state <= S_SUM;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SUM: begin
                    if (last_w) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STEP_W'(NUM_W)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_cnt   <= '0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/window_gap_cluster_mean_filter.sv -----
// Top level of the window gap cluster mean filter.
// Instantiates wgcm_ctrl and wgcm_dp; depends on wgcm_pkg.
//
//  channel | direction | tdata             | tuser
//  s_axis  | in        | [15:0] sample     | -
//  m_axis  | out       | [23:0] cluster_mean | [0] took_lower
//
// Each request runs through the odd-even sort passes, the rotating gap scan and
// cluster sum, and the one-bit-a-step divider. The result register lets a new
// request in while the previous result waits. Reset (synchronous, active low)
// zeroes the window.
module window_gap_cluster_mean_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [23:0] cluster_mean
    output logic        o_m_axis_tuser    // [0] took_lower
);
    import wgcm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    wgcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    wgcm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_sample (i_s_axis_tdata),
        .o_mean   (o_m_axis_tdata),
        .o_lower  (o_m_axis_tuser),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready)
    );

endmodule
